>>> src/gsrp_pkg.sv
package gsrp_pkg;

    localparam int VALUE_BITS_DEF = 20;
    localparam int RAW_W          = 20;
    localparam int SCALED_W       = 37;
    localparam int GAIN_W         = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] CH_CO2   = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_HUM   = 8'h48;  // 'H'
    localparam logic [7:0] CH_TEMP  = 8'h54;  // 'T'
    localparam logic [7:0] CH_MULT  = 8'h2E;  // '.'
    localparam logic [7:0] CH_ZERO  = 8'h47;  // 'G'
    localparam logic [7:0] CH_ALT   = 8'h53;  // 'S'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;

    localparam int TEMP_OFFSET = 1000;

    typedef enum logic [2:0] {
        KIND_CO2  = 3'd0,
        KIND_HUM  = 3'd1,
        KIND_TEMP = 3'd2,
        KIND_MULT = 3'd3,
        KIND_ZERO = 3'd4,
        KIND_ALT  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_CO2  = 3'd1,
        MODE_HUM  = 3'd2,
        MODE_TEMP = 3'd3,
        MODE_MULT = 3'd4,
        MODE_ZERO = 3'd5,
        MODE_ALT  = 3'd6
    } t_mode;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic t_mode header_mode(input logic [7:0] b);
        t_mode m;
        unique case (b)
            CH_CO2:  m = MODE_CO2;
            CH_HUM:  m = MODE_HUM;
            CH_TEMP: m = MODE_TEMP;
            CH_MULT: m = MODE_MULT;
            CH_ZERO: m = MODE_ZERO;
            CH_ALT:  m = MODE_ALT;
            default: m = MODE_IDLE;
        endcase
        return m;
    endfunction

    function automatic t_kind mode_kind(input t_mode m);
        t_kind k;
        unique case (m)
            MODE_HUM:  k = KIND_HUM;
            MODE_TEMP: k = KIND_TEMP;
            MODE_MULT: k = KIND_MULT;
            MODE_ZERO: k = KIND_ZERO;
            MODE_ALT:  k = KIND_ALT;
            default:   k = KIND_CO2;
        endcase
        return k;
    endfunction

endpackage

>>> src/gas_sensor_reply_parser_top.sv
// Gas sensor reply parser: takes one received ASCII byte per transfer and
// emits one result per completed reply (header letter, digits, carriage
// return). A byte is taken every cycle as long as the two-entry result queue
// has room; the front parser accumulates each digit as it takes it, which
// sets that rate. A result enters the queue on the same edge that takes the
// carriage return that ends its reply; once the output register is free, it
// moves from the queue through the scaling multiply into the output
// register. The back end owns the CO2 gain, so a multiplier reply affects
// only CO2 results queued after it.
module gas_sensor_reply_parser_top #(
    parameter int VALUE_BITS = gsrp_pkg::VALUE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [7:0]                           i_rx_byte,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [2:0]                           o_reply_kind,
    output logic [gsrp_pkg::RAW_W-1:0]           o_raw_number,
    output logic signed [gsrp_pkg::SCALED_W-1:0] o_scaled_number
);
    import gsrp_pkg::*;

    t_queue_status         q_status;
    logic                  take;
    logic                  push;
    logic                  pop;
    t_kind                 f_kind, q_kind;
    logic [VALUE_BITS-1:0] f_raw, q_raw;

    // Hold off input only when the queue cannot absorb a completed reply.
    assign o_stall = q_status.full;
    assign take    = i_valid && !q_status.full;

    // Front: classify bytes, accumulate digits, push on carriage return.
    gsrp_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx_byte),
        .o_push  (push),
        .o_kind  (f_kind),
        .o_raw   (f_raw)
    );

    // Queue: decouple the parser from output backpressure.
    gsrp_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_kind   (f_kind),
        .i_raw    (f_raw),
        .i_pop    (pop),
        .o_kind   (q_kind),
        .o_raw    (q_raw),
        .o_status (q_status)
    );

    // Back: scale by kind, track the CO2 gain, register the result.
    gsrp_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_status        (q_status),
        .i_kind          (q_kind),
        .i_raw           (q_raw),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_reply_kind    (o_reply_kind),
        .o_raw_number    (o_raw_number),
        .o_scaled_number (o_scaled_number)
    );

endmodule

>>> src/gsrp_front.sv
module gsrp_front #(
    parameter int VALUE_BITS = gsrp_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_byte,
    output logic                  o_push,
    output gsrp_pkg::t_kind       o_kind,
    output logic [VALUE_BITS-1:0] o_raw
);
    import gsrp_pkg::*;

    localparam int ACC_W = VALUE_BITS + 4;

    t_mode                 r_mode, n_mode;
    logic [VALUE_BITS-1:0] r_accum, n_accum;
    logic [ACC_W-1:0]      acc_ext;
    logic [ACC_W-1:0]      acc_next;
    logic                  is_digit;

    assign is_digit = (i_byte >= CH_DIG0) && (i_byte <= CH_DIG9);
    assign acc_ext  = {4'b0000, r_accum};
    assign acc_next = (acc_ext << 3) + (acc_ext << 1)
                    + ACC_W'(i_byte - CH_DIG0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_accum <= '0;
        end else begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        o_push  = 1'b0;
        if (i_take) begin
            unique case (r_mode)
                MODE_IDLE: begin
                    n_mode = header_mode(i_byte);
                end
                default: begin
                    if (is_digit) begin
                        // hold at all ones on overflow
                        n_accum = (acc_next[ACC_W-1:VALUE_BITS] != 4'b0000)
                                ? {VALUE_BITS{1'b1}} : acc_next[VALUE_BITS-1:0];
                    end else if (i_byte == CH_CR) begin
                        o_push  = 1'b1;
                        n_mode  = MODE_IDLE;
                        n_accum = '0;
                    end
                end
            endcase
        end
    end

    assign o_kind = mode_kind(r_mode);
    assign o_raw  = r_accum;

endmodule

>>> src/gsrp_queue.sv
module gsrp_queue #(
    parameter int VALUE_BITS = gsrp_pkg::VALUE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  gsrp_pkg::t_kind        i_kind,
    input  logic [VALUE_BITS-1:0]  i_raw,
    input  logic                   i_pop,
    output gsrp_pkg::t_kind        o_kind,
    output logic [VALUE_BITS-1:0]  o_raw,
    output gsrp_pkg::t_queue_status o_status
);
    import gsrp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_kind                 r_kind [QUEUE_DEPTH];
    logic [VALUE_BITS-1:0] r_raw  [QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_wr, r_rd;
    logic [CNT_W-1:0]      r_count;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_kind = r_kind[r_rd];
    assign o_raw  = r_raw[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_kind[r_wr] <= i_kind;
            r_raw[r_wr]  <= i_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

>>> src/gsrp_back.sv
module gsrp_back #(
    parameter int VALUE_BITS = gsrp_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gsrp_pkg::t_queue_status             i_status,
    input  gsrp_pkg::t_kind                     i_kind,
    input  logic [VALUE_BITS-1:0]               i_raw,
    output logic                                o_pop,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [2:0]                          o_reply_kind,
    output logic [gsrp_pkg::RAW_W-1:0]          o_raw_number,
    output logic signed [gsrp_pkg::SCALED_W-1:0] o_scaled_number
);
    import gsrp_pkg::*;

    localparam int PROD_W = VALUE_BITS + GAIN_W;

    logic [GAIN_W-1:0]                r_gain;
    logic                             r_valid;
    t_kind                            r_kind;
    logic [RAW_W-1:0]                 r_raw_out;
    logic signed [SCALED_W-1:0]       r_scaled;
    logic [PROD_W-1:0]                prod;
    logic [PROD_W+SCALED_W-1:0]       prod_ext;
    logic [VALUE_BITS+RAW_W-1:0]      raw_out_ext;
    logic [VALUE_BITS+SCALED_W-1:0]   raw_sc_ext;
    logic signed [SCALED_W-1:0]       raw_sc;
    logic signed [SCALED_W-1:0]       n_scaled;

    assign o_pop = !i_status.empty && (!r_valid || !i_stall);

    assign prod        = PROD_W'(i_raw) * PROD_W'(r_gain);
    assign prod_ext    = {{SCALED_W{1'b0}}, prod};
    assign raw_out_ext = {{RAW_W{1'b0}}, i_raw};
    assign raw_sc_ext  = {{SCALED_W{1'b0}}, i_raw};
    assign raw_sc      = $signed(raw_sc_ext[SCALED_W-1:0]);

    always_comb begin
        unique case (i_kind)
            KIND_CO2:  n_scaled = $signed(prod_ext[SCALED_W-1:0]);
            KIND_TEMP: n_scaled = raw_sc - SCALED_W'(TEMP_OFFSET);
            default:   n_scaled = raw_sc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_gain  <= GAIN_W'(1);
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (o_pop && i_kind == KIND_MULT) begin
                r_gain <= (i_raw[VALUE_BITS-1:GAIN_W] != '0)
                        ? {GAIN_W{1'b1}} : i_raw[GAIN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind    <= i_kind;
            r_raw_out <= raw_out_ext[RAW_W-1:0];
            r_scaled  <= n_scaled;
        end
    end

    assign o_valid         = r_valid;
    assign o_reply_kind    = r_kind;
    assign o_raw_number    = r_raw_out;
    assign o_scaled_number = r_scaled;

endmodule

>>> verif/gsrp_reply_checker.sv
module gsrp_reply_checker #(
    parameter int VALUE_BITS = gsrp_pkg::VALUE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [7:0]                           i_rx_byte,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic [2:0]                           i_reply_kind,
    input  logic [gsrp_pkg::RAW_W-1:0]           i_raw_number,
    input  logic signed [gsrp_pkg::SCALED_W-1:0] i_scaled_number,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_checked
);
    import gsrp_pkg::*;

    typedef struct packed {
        t_kind                kind;
        logic [RAW_W-1:0]     raw;
        logic [SCALED_W-1:0]  scaled;
    } t_reply;

    localparam logic [63:0] ACC_SAT  = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [63:0] GAIN_SAT = (64'd1 << GAIN_W) - 64'd1;

    t_reply              replies_due[$];
    t_reply              oldest;
    logic                in_reply;
    t_kind               open_kind;
    logic [63:0]         digit_sum;
    logic [GAIN_W-1:0]   co2_gain;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s at reply %0d: got 0x%0h, want 0x%0h",
                 what, o_checked, got, want);
        o_fail_count++;
    endtask

    // Advance the parser image by one received byte; queue a reply on a
    // carriage return that closes one.
    task automatic parse_byte(input logic [7:0] b);
        logic [63:0] next_sum;
        logic [63:0] scaled_full;
        t_reply      r;
        if (!in_reply) begin
            in_reply = 1'b1;
            case (b)
                CH_CO2:  open_kind = KIND_CO2;
                CH_HUM:  open_kind = KIND_HUM;
                CH_TEMP: open_kind = KIND_TEMP;
                CH_MULT: open_kind = KIND_MULT;
                CH_ZERO: open_kind = KIND_ZERO;
                CH_ALT:  open_kind = KIND_ALT;
                default: in_reply = 1'b0;
            endcase
        end else if (b >= CH_DIG0 && b <= CH_DIG9) begin
            next_sum  = digit_sum * 64'd10 + 64'(b - CH_DIG0);
            digit_sum = (next_sum > ACC_SAT) ? ACC_SAT : next_sum;
        end else if (b == CH_CR) begin
            case (open_kind)
                KIND_CO2:  scaled_full = digit_sum * 64'(co2_gain);
                KIND_TEMP: scaled_full = digit_sum - 64'(TEMP_OFFSET);
                KIND_MULT: begin
                    co2_gain    = (digit_sum > GAIN_SAT) ? GAIN_SAT[GAIN_W-1:0]
                                                         : digit_sum[GAIN_W-1:0];
                    scaled_full = digit_sum;
                end
                default:   scaled_full = digit_sum;
            endcase
            r.kind   = open_kind;
            r.raw    = digit_sum[RAW_W-1:0];
            r.scaled = scaled_full[SCALED_W-1:0];
            replies_due.push_back(r);
            in_reply  = 1'b0;
            digit_sum = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_reply  = 1'b0;
            open_kind = KIND_CO2;
            digit_sum = '0;
            co2_gain  = GAIN_W'(1);
            replies_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("unexpected reply", 64'(i_raw_number), 64'd0);
                end else begin
                    oldest = replies_due.pop_front();
                    if (i_reply_kind !== oldest.kind)
                        report_mismatch("reply_kind", 64'(i_reply_kind), 64'(oldest.kind));
                    if (i_raw_number !== oldest.raw)
                        report_mismatch("raw_number", 64'(i_raw_number), 64'(oldest.raw));
                    if (i_scaled_number !== oldest.scaled)
                        report_mismatch("scaled_number", 64'(i_scaled_number),
                                        64'(oldest.scaled));
                end
                o_checked++;
            end
            if (i_in_valid && !i_in_stall)
                parse_byte(i_rx_byte);
        end
        o_pending = replies_due.size();
    end

endmodule

>>> verif/tb_top.sv
module tb_top;
    import gsrp_pkg::*;

    // A long output hold must be far above the deepest point the parser can
    // buffer (two queued replies plus the output register).
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_BYTES    = 145;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [7:0]                 i_rx_byte;
    logic                       o_valid;
    logic                       i_stall;
    logic [2:0]                 o_reply_kind;
    logic [RAW_W-1:0]           o_raw_number;
    logic signed [SCALED_W-1:0] o_scaled_number;

    int fail_count;
    int replies_pending;
    int replies_checked;
    int bytes_sent;
    int quiet_cycles;

    // Calm flags switch a side to back-to-back operation; hold_req asks the
    // receiver for one long output stall.
    bit tx_calm;
    bit rx_calm;
    bit hold_req;

    gas_sensor_reply_parser_top #(
        .VALUE_BITS(VALUE_BITS_DEF)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_reply_kind   (o_reply_kind),
        .o_raw_number   (o_raw_number),
        .o_scaled_number(o_scaled_number)
    );

    // The checker watches both channels on its own and keeps the expected
    // replies; this module only drives stimulus and rules on the result.
    gsrp_reply_checker #(
        .VALUE_BITS(VALUE_BITS_DEF)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_reply_kind   (o_reply_kind),
        .i_raw_number   (o_raw_number),
        .i_scaled_number(o_scaled_number),
        .o_fail_count   (fail_count),
        .o_pending      (replies_pending),
        .o_checked      (replies_checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: count cycles with no transfer on either channel and give up
    // once the count gets far beyond any legal gap or stall.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one byte: wait out a random gap, then hold valid and the byte
    // until the transfer. Called and returning on a falling edge, so valid
    // that stays high for the next byte is never lowered in between.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int n = 0; n < s.len(); n++)
            send_byte(s[n]);
    endtask

    function automatic logic [7:0] header_of(input int k);
        case (k)
            0:       return CH_CO2;
            1:       return CH_HUM;
            2:       return CH_TEMP;
            3:       return CH_MULT;
            4:       return CH_ZERO;
            default: return CH_ALT;
        endcase
    endfunction

    // Any byte that the parser skips inside a reply.
    function automatic logic [7:0] skipped_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_CR || (b >= CH_DIG0 && b <= CH_DIG9));
        return b;
    endfunction

    // Well-formed reply with random content: maybe one stray byte while idle,
    // a header, mostly short digit runs with the odd overflowing one,
    // skipped characters mixed in, then the carriage return.
    task automatic send_reply();
        int n_digits;
        if ($urandom_range(0, 3) == 0)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(header_of($urandom_range(0, 5)));
        n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9)
                                               : $urandom_range(0, 4);
        repeat (n_digits) begin
            if ($urandom_range(0, 5) == 0)
                send_byte(skipped_byte());
            send_byte(CH_DIG0 + 8'($urandom_range(0, 9)));
        end
        send_byte(CH_CR);
    endtask

    // Noise: short run of arbitrary bytes, which may cut a reply short or
    // open one that the next reply's bytes then feed.
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Receiver: stall a random count before each result transfer, or hold
    // off for a long stretch once when asked.
    initial begin : result_side
        int w;
        i_stall = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                w = rx_calm ? 0 : $urandom_range(0, 8);
                if (w != 0) begin
                    i_stall <= 1'b1;
                    repeat (w) @(negedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            @(negedge i_clk);
        end
    end

    initial begin : byte_side
        int target;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_rx_byte = 8'h00;
        tx_calm   = 1'b0;
        rx_calm   = 1'b0;
        hold_req  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: carriage return and a digit while idle, temperature with
        // no digits (scaled below zero), a plain CO2 reply, an overflowing
        // multiplier that also saturates the gain, a header letter inside a
        // reply, and an all-ones byte skipped inside a reply.
        send_text("\r7");
        send_text("T\r");
        send_text("Z42\r");
        send_text(".9999999\r");
        send_text("GH\r");
        send_text("S1");
        send_byte(8'hFF);
        send_byte(CH_CR);

        // Pressure: after the next result, hold the output off while short
        // replies keep coming back to back, so the result queue fills and
        // the parser stalls its input.
        tx_calm  = 1'b1;
        hold_req = 1'b1;
        repeat (12) send_text("H5\r");
        tx_calm  = 1'b0;

        // Random: four phases covering every mix of busy and calm sides.
        for (int ph = 0; ph < 4; ph++) begin
            tx_calm = ph[0];
            rx_calm = ph[1];
            target  = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                if ($urandom_range(0, 99) < 85)
                    send_reply();
                else
                    send_noise();
            end
        end
        i_valid <= 1'b0;

        // Drain: wait for every expected reply, then keep the clock running to
        // catch anything the block might still put out.
        while (replies_pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("Run covered %0d bytes and %0d checked replies of all kinds,",
                 bytes_sent, replies_checked);
        $display("with idle noise, digit overflow, gain saturation and a long output hold.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> gas_sensor_reply_parser_top.f
src/gsrp_pkg.sv
src/gsrp_front.sv
src/gsrp_queue.sv
src/gsrp_back.sv
src/gas_sensor_reply_parser_top.sv
verif/gsrp_reply_checker.sv
verif/tb_top.sv
